>>> hw/rtl/play_state_rhythm_divider_assert.svh
// ----------------------------------------------------------------------------
// play state rhythm divider assertion macros
// clocked assertion helpers shared by the top and core rtl modules
// ----------------------------------------------------------------------------
`ifndef PLAY_STATE_RHYTHM_DIVIDER_ASSERT_SVH
`define PLAY_STATE_RHYTHM_DIVIDER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define PSRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define PSRD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

>>> hw/rtl/psrd_pkg.sv
// ----------------------------------------------------------------------------
// psrd_pkg
// shared types and constants of the play state rhythm divider
// ----------------------------------------------------------------------------
`default_nettype none

package psrd_pkg;

    localparam int NUM_RHYTHMS   = 4;
    localparam int PERIOD_BITS   = 18;
    localparam int CFG_SLOTS     = 4;
    localparam int DIV_BITS      = 5;
    localparam int TGT_BITS      = 2;
    localparam int STEP_BITS     = 3;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 5;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 16;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_A = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_B = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_C = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIVISOR_D = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_A  = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_B  = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_C  = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_D  = 4'd7;

    // target codes
    localparam logic [TGT_BITS-1:0] TGT_NONE = 2'd0;
    localparam logic [TGT_BITS-1:0] TGT_SEQ1 = 2'd1;
    localparam logic [TGT_BITS-1:0] TGT_SEQ2 = 2'd2;
    localparam logic [TGT_BITS-1:0] TGT_BOTH = 2'd3;

    localparam logic [DIV_BITS-1:0] DIVISOR_RESET = 5'd1;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_GATED = 2'd1,
        MODE_SEQ   = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CFG_SLOTS-1:0][DIV_BITS-1:0] divisor;
        logic [CFG_SLOTS-1:0][TGT_BITS-1:0] target;
    } t_cfg;

    typedef struct packed {
        logic                   play_press;
        logic                   gate_press;
        logic [PERIOD_BITS-1:0] beat_period;
    } t_in_item;

    typedef struct packed {
        t_mode                play_mode;
        logic                 env_trigger;
        logic                 env_release;
        logic                 sustain_on;
        logic                 seq_restart;
        logic [STEP_BITS-1:0] seq1_steps;
        logic [STEP_BITS-1:0] seq2_steps;
        logic                 seq1_active;
        logic                 seq2_active;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/play_state_rhythm_divider.sv
// ----------------------------------------------------------------------------
// play_state_rhythm_divider
// play mode and rhythm divider, one item per audio sample
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           play, gate, beat period
//  m_axis    out        tvalid / tready           mode, envelope, sequence ctl
//  cfg       in         valid / ready             register index, write data
//
//  one item per cycle while results are taken; an item passes the input
//  register, the single pass of state logic and then the result register
//  synchronous active-low reset clears mode, counters and active flags and sets sustain, no sweep
//  a stalled result holds the result register; the input register still
//  takes an item and holds it until the result register frees
// ----------------------------------------------------------------------------
`default_nettype none

`include "play_state_rhythm_divider_assert.svh"

module play_state_rhythm_divider (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // play_press[0], gate_press[1], beat_period[19:2], zero pad
    input  wire logic [psrd_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // play_mode[1:0], env_trigger[2], env_release[3], sustain_on[4],
    // seq_restart[5], seq1_steps[8:6], seq2_steps[11:9], seq1_active[12],
    // seq2_active[13], zero pad
    output logic [psrd_pkg::OUT_TDATA_BITS-1:0]      o_m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [psrd_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [psrd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int PB = psrd_pkg::PERIOD_BITS;
    localparam int SB = psrd_pkg::STEP_BITS;
    localparam int RES_BITS = 8 + 2 * SB;

    psrd_pkg::t_cfg      w_cfg;
    psrd_pkg::t_in_item  r_in_item;
    logic                r_in_valid;
    psrd_pkg::t_result   w_result;
    psrd_pkg::t_result   r_out;
    logic                r_out_valid;
    logic                w_step;
    logic                w_in_fire;

    psrd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    psrd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    assign o_m_axis_tdata = {
        (psrd_pkg::OUT_TDATA_BITS - RES_BITS)'(0),
        r_out.seq2_active,
        r_out.seq1_active,
        r_out.seq2_steps,
        r_out.seq1_steps,
        r_out.seq_restart,
        r_out.sustain_on,
        r_out.env_release,
        r_out.env_trigger,
        r_out.play_mode
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_step) begin
                r_in_valid <= 1'b0;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, input item cleared so the core never sees unknowns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_item <= '0;
        end else if (w_in_fire) begin
            r_in_item.play_press  <= i_s_axis_tdata[0];
            r_in_item.gate_press  <= i_s_axis_tdata[1];
            r_in_item.beat_period <= i_s_axis_tdata[PB+1:2];
        end
        if (w_step) begin
            r_out <= w_result;
        end
    end

    `PSRD_ASSERT_NEXT(a_step_fills_result, w_step, r_out_valid,
        "result register empty after a step")
    `PSRD_ASSERT_NEXT(a_held_item_kept, r_in_valid && !w_step, r_in_valid,
        "waiting input item dropped")
    `PSRD_ASSERT(a_ready_when_result_free, r_out_valid || o_s_axis_tready,
        "input not ready while result register is free")

endmodule

`default_nettype wire

>>> hw/rtl/psrd_cfg.sv
// ----------------------------------------------------------------------------
// psrd_cfg
// divisor and target registers written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module psrd_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psrd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [psrd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output psrd_pkg::t_cfg                         o_cfg
);

    psrd_pkg::t_cfg r_cfg;
    psrd_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                psrd_pkg::CFG_DIVISOR_A: n_cfg.divisor[0] = i_cfg_data[psrd_pkg::DIV_BITS-1:0];
                psrd_pkg::CFG_DIVISOR_B: n_cfg.divisor[1] = i_cfg_data[psrd_pkg::DIV_BITS-1:0];
                psrd_pkg::CFG_DIVISOR_C: n_cfg.divisor[2] = i_cfg_data[psrd_pkg::DIV_BITS-1:0];
                psrd_pkg::CFG_DIVISOR_D: n_cfg.divisor[3] = i_cfg_data[psrd_pkg::DIV_BITS-1:0];
                psrd_pkg::CFG_TARGET_A:  n_cfg.target[0]  = i_cfg_data[psrd_pkg::TGT_BITS-1:0];
                psrd_pkg::CFG_TARGET_B:  n_cfg.target[1]  = i_cfg_data[psrd_pkg::TGT_BITS-1:0];
                psrd_pkg::CFG_TARGET_C:  n_cfg.target[2]  = i_cfg_data[psrd_pkg::TGT_BITS-1:0];
                psrd_pkg::CFG_TARGET_D:  n_cfg.target[3]  = i_cfg_data[psrd_pkg::TGT_BITS-1:0];
                // indexes past the list are dropped
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < psrd_pkg::CFG_SLOTS; i++) begin
                r_cfg.divisor[i] <= psrd_pkg::DIVISOR_RESET;
                r_cfg.target[i]  <= psrd_pkg::TGT_NONE;
            end
            r_cfg.target[0] <= psrd_pkg::TGT_SEQ1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psrd_core.sv
// ----------------------------------------------------------------------------
// psrd_core
// play mode state machine, base-beat counter and rhythm counters
// ----------------------------------------------------------------------------
`default_nettype none

`include "play_state_rhythm_divider_assert.svh"

module psrd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire psrd_pkg::t_in_item i_item,
    input  wire psrd_pkg::t_cfg     i_cfg,
    output psrd_pkg::t_result       o_result
);

    psrd_pkg::t_mode                        r_mode;
    psrd_pkg::t_mode                        n_mode;
    logic [psrd_pkg::PERIOD_BITS-1:0]       r_beat;
    logic [psrd_pkg::PERIOD_BITS-1:0]       n_beat;
    logic [psrd_pkg::DIV_BITS-1:0]          r_cnt [psrd_pkg::NUM_RHYTHMS];
    logic [psrd_pkg::DIV_BITS-1:0]          n_cnt [psrd_pkg::NUM_RHYTHMS];
    logic                                   r_sustain;
    logic                                   n_sustain;
    logic [psrd_pkg::TGT_BITS-1:0]          r_active;
    logic [psrd_pkg::TGT_BITS-1:0]          n_active;

    logic [psrd_pkg::PERIOD_BITS:0]         w_beat_inc;
    logic                                   w_beat_hit;
    logic [psrd_pkg::DIV_BITS:0]            w_cnt_inc [psrd_pkg::NUM_RHYTHMS];
    logic [psrd_pkg::NUM_RHYTHMS-1:0]       w_wrap;

    assign w_beat_inc = {1'b0, r_beat} + (psrd_pkg::PERIOD_BITS+1)'(1);
    assign w_beat_hit = (r_mode == psrd_pkg::MODE_SEQ) && !i_item.play_press
                        && (w_beat_inc >= {1'b0, i_item.beat_period});

    always_comb begin
        for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
            w_cnt_inc[i] = {1'b0, r_cnt[i]} + (psrd_pkg::DIV_BITS+1)'(1);
            w_wrap[i]    = (i_cfg.target[i] != psrd_pkg::TGT_NONE)
                           && (w_cnt_inc[i] >= {1'b0, i_cfg.divisor[i]});
        end
    end

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_beat    = r_beat;
        n_sustain = r_sustain;
        n_active  = r_active;
        for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        case (r_mode)
            psrd_pkg::MODE_OFF: begin
                if (i_item.play_press) begin
                    n_mode    = psrd_pkg::MODE_SEQ;
                    n_sustain = 1'b0;
                    // loaded with the period so the next sample is a beat
                    n_beat    = i_item.beat_period;
                end else if (i_item.gate_press) begin
                    n_mode = psrd_pkg::MODE_GATED;
                end
            end
            psrd_pkg::MODE_GATED: begin
                if (i_item.gate_press) begin
                    n_mode = psrd_pkg::MODE_OFF;
                end
            end
            psrd_pkg::MODE_SEQ: begin
                if (i_item.play_press) begin
                    n_mode    = psrd_pkg::MODE_OFF;
                    n_sustain = 1'b1;
                end else if (w_beat_hit) begin
                    n_beat   = '0;
                    n_active = '0;
                    for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
                        if (i_cfg.target[i] != psrd_pkg::TGT_NONE) begin
                            n_active = n_active | i_cfg.target[i];
                            n_cnt[i] = w_wrap[i] ? '0
                                       : w_cnt_inc[i][psrd_pkg::DIV_BITS-1:0];
                        end
                    end
                end else begin
                    n_beat = w_beat_inc[psrd_pkg::PERIOD_BITS-1:0];
                end
            end
            default: begin
                n_mode = psrd_pkg::MODE_OFF;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_result             = '0;
        o_result.play_mode   = n_mode;
        o_result.sustain_on  = n_sustain;
        o_result.seq1_active = n_active[0];
        o_result.seq2_active = n_active[1];
        o_result.seq_restart = (r_mode == psrd_pkg::MODE_OFF) && i_item.play_press;
        o_result.env_release = ((r_mode == psrd_pkg::MODE_GATED) && i_item.gate_press)
                               || ((r_mode == psrd_pkg::MODE_SEQ) && i_item.play_press);
        o_result.env_trigger = ((r_mode == psrd_pkg::MODE_OFF) && !i_item.play_press
                                && i_item.gate_press)
                               || (w_beat_hit && (|w_wrap));
        if (w_beat_hit) begin
            for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
                o_result.seq1_steps = o_result.seq1_steps
                    + psrd_pkg::STEP_BITS'(w_wrap[i] & i_cfg.target[i][0]);
                o_result.seq2_steps = o_result.seq2_steps
                    + psrd_pkg::STEP_BITS'(w_wrap[i] & i_cfg.target[i][1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= psrd_pkg::MODE_OFF;
            r_beat    <= '0;
            r_sustain <= 1'b1;
            r_active  <= '0;
            for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_beat    <= n_beat;
            r_sustain <= n_sustain;
            r_active  <= n_active;
            for (int i = 0; i < psrd_pkg::NUM_RHYTHMS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    `PSRD_ASSERT(a_restart_enters_seq,
        !o_result.seq_restart || (n_mode == psrd_pkg::MODE_SEQ),
        "sequence restart without entering sequencing")
    `PSRD_ASSERT_NEXT(a_beat_clears_count, i_step && w_beat_hit, r_beat == '0,
        "beat counter not cleared after a base beat")
    `PSRD_ASSERT(a_steps_trigger,
        ((o_result.seq1_steps == '0) && (o_result.seq2_steps == '0))
        || o_result.env_trigger,
        "sequence advance without envelope trigger")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// play state rhythm divider testbench
// drives audio-sample items through the stream port with random gaps and
// output stalls, rewrites the divisor and target registers between phases,
// and checks every result tick against a cycle-free predictor of the play
// mode, base beat and rhythm counters
// ----------------------------------------------------------------------------

module tb_top;

    import psrd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SAMPLES_PER_PHASE = 90;
    localparam int NUM_PHASES = 7;
    localparam int MAX_PRINTED = 40;
    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 4'd15;
    localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

    class tick_predictor;
        logic [DIV_BITS-1:0] divisor [NUM_RHYTHMS];
        logic [TGT_BITS-1:0] target [NUM_RHYTHMS];
        t_mode               mode;
        int unsigned         beat_count;
        int unsigned         rhythm_count [NUM_RHYTHMS];
        logic                sustain;
        logic [1:0]          active;
        t_result             expected_ticks[$];
        int                  mismatches;
        int                  ticks_seen;

        function new();
            for (int i = 0; i < NUM_RHYTHMS; i++) begin
                divisor[i] = DIVISOR_RESET;
                target[i] = TGT_NONE;
                rhythm_count[i] = 0;
            end
            target[0] = TGT_SEQ1;
            mode = MODE_OFF;
            beat_count = 0;
            sustain = 1'b1;
            active = 2'b00;
            mismatches = 0;
            ticks_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            if (idx <= CFG_DIVISOR_D) begin
                divisor[idx - CFG_DIVISOR_A] = val;
            end else if (idx <= CFG_TARGET_D) begin
                target[idx - CFG_TARGET_A] = val[TGT_BITS-1:0];
            end
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTED)
                $display("[%0t] tick %0d: %s", $realtime, ticks_seen, msg);
            mismatches++;
        endtask

        task take_sample(logic play, logic gate, logic [PERIOD_BITS-1:0] period);
            t_result     r;
            int unsigned next;
            int unsigned cnt;
            int          steps1;
            int          steps2;
            r = '0;
            steps1 = 0;
            steps2 = 0;
            case (mode)
                MODE_GATED: begin
                    if (gate) begin
                        mode = MODE_OFF;
                        r.env_release = 1'b1;
                    end
                end
                MODE_SEQ: begin
                    if (play) begin
                        mode = MODE_OFF;
                        r.env_release = 1'b1;
                        sustain = 1'b1;
                    end else begin
                        next = beat_count + 1;
                        if (next >= period) begin
                            // base beat: flags rebuilt from the targets
                            active = 2'b00;
                            for (int i = 0; i < NUM_RHYTHMS; i++) begin
                                if (target[i] != TGT_NONE) begin
                                    active |= target[i];
                                    cnt = rhythm_count[i] + 1;
                                    if (cnt >= divisor[i]) begin
                                        cnt = 0;
                                        r.env_trigger = 1'b1;
                                        if (target[i] == TGT_SEQ1 || target[i] == TGT_BOTH)
                                            steps1++;
                                        if (target[i] == TGT_SEQ2 || target[i] == TGT_BOTH)
                                            steps2++;
                                    end
                                    rhythm_count[i] = cnt & 32'h1f;
                                end
                            end
                            beat_count = 0;
                        end else begin
                            beat_count = next;
                        end
                    end
                end
                default: begin
                    if (play) begin
                        mode = MODE_SEQ;
                        sustain = 1'b0;
                        r.seq_restart = 1'b1;
                        beat_count = period;
                    end else if (gate) begin
                        mode = MODE_GATED;
                        r.env_trigger = 1'b1;
                    end
                end
            endcase
            r.play_mode = mode;
            r.sustain_on = sustain;
            r.seq1_steps = steps1[STEP_BITS-1:0];
            r.seq2_steps = steps2[STEP_BITS-1:0];
            r.seq1_active = active[0];
            r.seq2_active = active[1];
            expected_ticks.push_back(r);
        endtask

        task check_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d want %0d", name, got, want));
        endtask

        task check_tick(logic [OUT_TDATA_BITS-1:0] d);
            t_result want;
            ticks_seen++;
            if (expected_ticks.size() == 0) begin
                report($sformatf("result 0x%04h with nothing expected", d));
            end else begin
                want = expected_ticks.pop_front();
                check_field("play_mode", d[1:0], want.play_mode);
                check_field("env_trigger", d[2], want.env_trigger);
                check_field("env_release", d[3], want.env_release);
                check_field("sustain_on", d[4], want.sustain_on);
                check_field("seq_restart", d[5], want.seq_restart);
                check_field("seq1_steps", d[8:6], want.seq1_steps);
                check_field("seq2_steps", d[11:9], want.seq2_steps);
                check_field("seq1_active", d[12], want.seq1_active);
                check_field("seq2_active", d[13], want.seq2_active);
            end
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      s_tready;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    int cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    tick_predictor sb = new();

    play_state_rhythm_divider dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // handshake monitors, sampled before the edge takes effect
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.take_sample(s_tdata[0], s_tdata[1], s_tdata[PERIOD_BITS+1:2]);
            if (m_tvalid && m_tready)
                sb.check_tick(m_tdata);
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    initial begin : recv_pacing
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < recv_stall_pct)
                    stall = pick_gap();
            end
        end
    end

    // valid stays high into the next item unless a gap is taken
    task automatic send_sample(logic play, logic gate, logic [PERIOD_BITS-1:0] period);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_BITS - PERIOD_BITS - 2){1'b0}}, period, gate, play};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic random_sample();
        logic                   play;
        logic                   gate;
        logic [PERIOD_BITS-1:0] period;
        int                     r;
        // get out of off quickly, most time belongs in sequencing
        play = ($urandom_range(0, 99) < (sb.mode == MODE_OFF ? 30 : 4));
        gate = ($urandom_range(0, 99) < 8);
        r = $urandom_range(0, 99);
        if (r < 65)
            period = PERIOD_BITS'($urandom_range(0, 4));
        else if (r < 92)
            period = PERIOD_BITS'($urandom_range(5, 24));
        else
            period = PERIOD_BITS'($urandom);
        send_sample(play, gate, period);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_ticks.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic setup_phase(int p);
        case (p)
            1: begin
                for (int i = 0; i < NUM_RHYTHMS; i++) begin
                    cfg_write(CFG_IDX_BITS'(CFG_DIVISOR_A + i), 5'd1);
                    cfg_write(CFG_IDX_BITS'(CFG_TARGET_A + i), CFG_DATA_BITS'(TGT_BOTH));
                end
            end
            2: begin
                for (int i = 0; i < NUM_RHYTHMS; i++)
                    cfg_write(CFG_IDX_BITS'(CFG_DIVISOR_A + i), 5'd16);
                cfg_write(CFG_TARGET_A, CFG_DATA_BITS'(TGT_SEQ1));
                cfg_write(CFG_TARGET_B, CFG_DATA_BITS'(TGT_SEQ2));
                cfg_write(CFG_TARGET_C, CFG_DATA_BITS'(TGT_BOTH));
                cfg_write(CFG_TARGET_D, CFG_DATA_BITS'(TGT_NONE));
            end
            3: begin
                // zero divisors, all-ones divisor, masked targets, dead indexes
                cfg_write(CFG_DIVISOR_A, 5'd0);
                cfg_write(CFG_DIVISOR_B, 5'd0);
                cfg_write(CFG_DIVISOR_C, 5'd31);
                cfg_write(CFG_DIVISOR_D, 5'd2);
                cfg_write(CFG_TARGET_A, 5'b11111);
                cfg_write(CFG_TARGET_B, 5'b00110);
                cfg_write(CFG_TARGET_C, 5'b10101);
                cfg_write(CFG_TARGET_D, 5'b11100);
                cfg_write(CFG_UNUSED_LO, 5'd0);
                cfg_write(CFG_UNUSED_HI, 5'd31);
            end
            default: begin
                for (int i = 0; i < NUM_RHYTHMS; i++) begin
                    cfg_write(CFG_IDX_BITS'(CFG_DIVISOR_A + i),
                              CFG_DATA_BITS'($urandom_range(1, 16)));
                    cfg_write(CFG_IDX_BITS'(CFG_TARGET_A + i),
                              CFG_DATA_BITS'($urandom_range(0, 3)));
                end
            end
        endcase
        cfg_done();
        case (p)
            5: begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            6: begin
                send_gap_pct = 50;
                recv_stall_pct = 50;
            end
            default: begin
                send_gap_pct = 25;
                recv_stall_pct = 25;
            end
        endcase
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass with the reset register values
        send_gap_pct = 20;
        recv_stall_pct = 20;
        send_sample(1'b0, 1'b0, 18'd5);
        send_sample(1'b0, 1'b1, 18'd5);      // off to gated
        send_sample(1'b1, 1'b0, 18'd5);      // play ignored while gated
        send_sample(1'b1, 1'b1, 18'd5);      // gate releases, play ignored
        send_sample(1'b1, 1'b1, 18'd3);      // both while off, play wins
        send_sample(1'b0, 1'b1, 18'd3);      // gate ignored while sequencing
        send_sample(1'b0, 1'b0, 18'd0);      // zero period beats every sample
        send_sample(1'b0, 1'b0, 18'd0);
        send_sample(1'b0, 1'b0, PERIOD_MAX);
        send_sample(1'b0, 1'b0, PERIOD_MAX);
        send_sample(1'b0, 1'b0, 18'd1);      // period dropped under the count
        send_sample(1'b0, 1'b0, 18'd2);
        send_sample(1'b0, 1'b0, 18'd2);
        send_sample(1'b1, 1'b0, 18'd2);      // stop
        send_sample(1'b0, 1'b0, 18'd2);
        send_sample(1'b1, 1'b0, PERIOD_MAX); // start at the largest period
        send_sample(1'b0, 1'b0, PERIOD_MAX);
        send_sample(1'b0, 1'b0, 18'h2aaaa);
        send_sample(1'b0, 1'b0, 18'h15555);
        send_sample(1'b1, 1'b1, 18'd7);
        send_sample(1'b0, 1'b1, 18'd0);
        send_sample(1'b0, 1'b0, 18'd0);
        send_sample(1'b0, 1'b1, 18'd0);
        drain();

        for (int p = 1; p <= NUM_PHASES; p++) begin
            setup_phase(p);
            repeat (SAMPLES_PER_PHASE) random_sample();
            drain();
        end

        if (sb.mismatches == 0 && sb.expected_ticks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
